@@ rtl/seven_segment_scan_shifter_unit_macros.svh @@
// Assertion macros shared by the seven-segment scan shifter RTL.
`ifndef SEVEN_SEGMENT_SCAN_SHIFTER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_SHIFTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clk edge out of reset.
`define SSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising clk edge out of reset.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSS_ASSERT_IMPL(label, ante, cons, msg)
`define SSS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/sss_pkg.sv @@
// Constants, types and helpers for the seven-segment scan shifter.
package sss_pkg;

    localparam int MAX_DIGITS        = 8;
    localparam int WORD_BITS         = 16;
    localparam int DWELL_BITS        = 20;
    localparam int SEG_BITS          = WORD_BITS / 2;
    localparam int DIGIT_W           = $clog2(MAX_DIGITS);
    localparam int COUNT_W           = $clog2(MAX_DIGITS + 1);
    localparam int BITSEL_W          = $clog2(WORD_BITS);
    localparam int POS_W             = $clog2(SEG_BITS);
    localparam int LATCH_PHASE       = 2 * WORD_BITS;
    localparam int PHASE_W           = $clog2(LATCH_PHASE + 2);
    localparam int CHAIN_W           = 2;
    localparam int DIGITS_PER_MODULE = 4;
    localparam int CHAIN_RESET       = 1;
    localparam int DWELL_RESET       = 1000;
    localparam int IDX_W             = 3;
    localparam int SCAN_POS_W        = 3;
    localparam int CFG_IDX_W         = 1;

    // Item opcodes
    typedef enum logic
    {
        MODE_WRITE = 1'b0,
        MODE_TICK  = 1'b1
    } mode_e;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_MODULE_CHAIN = 1'b0,
        REG_DWELL_TICKS  = 1'b1
    } cfg_reg_e;

    typedef struct packed
    {
        logic                  mode;
        logic [IDX_W-1:0]      digit_index;
        logic [SEG_BITS-1:0]   digit_value;
    } item_t;

    typedef struct packed
    {
        logic [CHAIN_W-1:0]    chain;
        logic [DWELL_BITS-1:0] dwell;
    } cfg_t;

    typedef struct packed
    {
        logic latch;
        logic data;
        logic clk;
    } pins_t;

    typedef struct packed
    {
        pins_t                 pins;
        logic [DIGIT_W-1:0]    pos;
    } result_t;

    // Digits scanned for a chain setting: 0 acts as 1, above 2 acts as 2.
    function automatic logic [COUNT_W-1:0] digit_total(input logic [CHAIN_W-1:0] chain);
        int c;
        int n;
        c = int'(chain);
        if (c == 0)
            c = 1;
        if (c > 2)
            c = 2;
        n = c * DIGITS_PER_MODULE;
        if (n > MAX_DIGITS)
            n = MAX_DIGITS;
        return COUNT_W'(n);
    endfunction

endpackage

@@ rtl/sss_store.sv @@
// Digit slot store: one segment byte per digit, cleared at reset.
module sss_store
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [sss_pkg::IDX_W-1:0]             wr_idx,
    input  logic [sss_pkg::SEG_BITS-1:0]          wr_data,
    input  logic [sss_pkg::DIGIT_W-1:0]           rd_idx,
    output logic [sss_pkg::SEG_BITS-1:0]          rd_data
);

    logic [sss_pkg::SEG_BITS-1:0] slot_reg [sss_pkg::MAX_DIGITS];

    // Drop writes to slots beyond the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sss_pkg::MAX_DIGITS; i++)
                slot_reg[i] <= '0;
        end
        else if (wr_en && (int'(wr_idx) < sss_pkg::MAX_DIGITS))
        begin
            slot_reg[wr_idx[sss_pkg::DIGIT_W-1:0]] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_idx];

endmodule

@@ rtl/sss_scan.sv @@
// Scan sequencer: phase and dwell counters, shift word and pin levels.
`include "seven_segment_scan_shifter_unit_macros.svh"
module sss_scan
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  sss_pkg::item_t                     item,
    input  sss_pkg::cfg_t                      cfg,
    input  logic [sss_pkg::SEG_BITS-1:0]       rd_data,
    output logic [sss_pkg::DIGIT_W-1:0]        rd_idx,
    output sss_pkg::result_t                   result
);

    logic [sss_pkg::DIGIT_W-1:0]    scan_reg, scan_next;
    logic [sss_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [sss_pkg::DWELL_BITS-1:0] dwell_reg, dwell_next;
    logic [sss_pkg::WORD_BITS-1:0]  word_reg, word_next;
    sss_pkg::pins_t                 pins_reg, pins_next;

    logic [sss_pkg::COUNT_W-1:0]    count;
    logic                           tick;
    logic                           is_shift;
    logic                           is_latch;
    logic                           is_hold;
    logic                           advance;
    logic                           begin_word;
    logic [sss_pkg::COUNT_W-1:0]    sd_base;
    logic [sss_pkg::DIGIT_W-1:0]    sd;
    logic [sss_pkg::COUNT_W-1:0]    pos_full;
    logic [sss_pkg::SEG_BITS-1:0]   onehot;
    logic [sss_pkg::WORD_BITS-1:0]  word;
    logic [sss_pkg::PHASE_W-1:0]    eff_phase;
    logic [sss_pkg::BITSEL_W-1:0]   bit_sel;
    sss_pkg::pins_t                 shift_pins;

    // Decode the phase of the current digit
    always_comb
    begin
        count    = sss_pkg::digit_total(cfg.chain);
        tick     = fire && (item.mode == sss_pkg::MODE_TICK);
        is_shift = (phase_reg < sss_pkg::PHASE_W'(sss_pkg::LATCH_PHASE));
        is_latch = (phase_reg == sss_pkg::PHASE_W'(sss_pkg::LATCH_PHASE));
        is_hold  = (dwell_reg < cfg.dwell);
        advance  = !is_shift && !is_latch && !is_hold;
        begin_word = advance || (is_shift && (phase_reg == '0));
    end

    // Pick the digit to shift; restart at zero past the count
    always_comb
    begin
        sd_base = advance ? (sss_pkg::COUNT_W'(scan_reg) + sss_pkg::COUNT_W'(1))
                          : sss_pkg::COUNT_W'(scan_reg);
        sd      = (sd_base >= count) ? '0 : sd_base[sss_pkg::DIGIT_W-1:0];
        rd_idx  = sd;
    end

    // Build the word and select the bit for this phase
    always_comb
    begin
        pos_full  = count - sss_pkg::COUNT_W'(1) - sss_pkg::COUNT_W'(sd);
        onehot    = sss_pkg::SEG_BITS'(1) << pos_full[sss_pkg::POS_W-1:0];
        word      = begin_word ? {rd_data, onehot} : word_reg;
        eff_phase = advance ? '0 : phase_reg;
        bit_sel   = sss_pkg::BITSEL_W'(sss_pkg::WORD_BITS - 1)
                    - eff_phase[sss_pkg::BITSEL_W:1];
        if (!eff_phase[0])
        begin
            shift_pins.latch = 1'b0;
            shift_pins.data  = word[bit_sel];
            shift_pins.clk   = 1'b0;
        end
        else
        begin
            shift_pins.latch = 1'b0;
            shift_pins.data  = pins_reg.data;
            shift_pins.clk   = 1'b1;
        end
    end

    // Advance counters and pins on a tick; hold on a slot write
    always_comb
    begin
        scan_next  = scan_reg;
        phase_next = phase_reg;
        dwell_next = dwell_reg;
        word_next  = word_reg;
        pins_next  = pins_reg;
        if (tick)
        begin
            if (is_shift || advance)
            begin
                pins_next  = shift_pins;
                phase_next = eff_phase + sss_pkg::PHASE_W'(1);
                // The digit is only picked again when a new word starts
                scan_next  = begin_word ? sd : scan_reg;
                word_next  = word;
                if (advance)
                    dwell_next = '0;
            end
            else if (is_latch)
            begin
                pins_next.latch = 1'b1;
                phase_next      = sss_pkg::PHASE_W'(sss_pkg::LATCH_PHASE + 1);
                dwell_next      = '0;
            end
            else
            begin
                pins_next.latch = 1'b0;
                dwell_next      = dwell_reg + sss_pkg::DWELL_BITS'(1);
            end
        end
        result.pins = pins_next;
        result.pos  = scan_next;
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            phase_reg <= '0;
            dwell_reg <= '0;
            word_reg  <= '0;
            pins_reg  <= '0;
        end
        else
        begin
            scan_reg  <= scan_next;
            phase_reg <= phase_next;
            dwell_reg <= dwell_next;
            word_reg  <= word_next;
            pins_reg  <= pins_next;
        end
    end

    `SSS_ASSERT_IMPL(a_phase_range, 1'b1, phase_reg <= sss_pkg::PHASE_W'(sss_pkg::LATCH_PHASE + 1), "phase counter out of range")
    `SSS_ASSERT_IMPL(a_latch_phase, pins_reg.latch, phase_reg == sss_pkg::PHASE_W'(sss_pkg::LATCH_PHASE + 1), "latch high outside latch phase")
    `SSS_ASSERT_IMPL(a_clk_phase, pins_reg.clk, (phase_reg == sss_pkg::PHASE_W'(sss_pkg::LATCH_PHASE + 1)) || (!phase_reg[0] && (phase_reg != '0)), "shift clock high in wrong phase")
    `SSS_ASSERT_NEXT(a_write_holds, fire && (item.mode == sss_pkg::MODE_WRITE), $stable(pins_reg) && $stable(scan_reg), "slot write moved the scan")

endmodule

@@ rtl/seven_segment_scan_shifter_unit.sv @@
// Top level of the seven-segment scan shifter: handshakes, config and output register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   input    | in_valid / in_stall  | mode, digit_index, digit_value
//   result   | out_valid / out_stall| shift_clock, shift_data, latch_out, scan_position
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while results are not stalled; a result passes
// through the input register and then the scan update into the output register.
// Reset clears the digit store, the counters and the pin levels.
// A stalled result holds the output register; the input register still
// takes one more transaction before in_stall rises.
`include "seven_segment_scan_shifter_unit_macros.svh"
module seven_segment_scan_shifter_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   mode,
    input  logic [sss_pkg::IDX_W-1:0]              digit_index,
    input  logic [sss_pkg::SEG_BITS-1:0]           digit_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   shift_clock,
    output logic                                   shift_data,
    output logic                                   latch_out,
    output logic [sss_pkg::SCAN_POS_W-1:0]         scan_position,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sss_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sss_pkg::DWELL_BITS-1:0]         cfg_data
);

    sss_pkg::item_t                 item_reg;
    logic                           in_full_reg, in_full_next;
    logic                           out_valid_reg, out_valid_next;
    sss_pkg::result_t               res_reg;
    sss_pkg::cfg_t                  cfg_reg;
    sss_pkg::result_t               result;
    logic                           accept_in;
    logic                           fire;
    logic [sss_pkg::DIGIT_W-1:0]    rd_idx;
    logic [sss_pkg::SEG_BITS-1:0]   rd_data;

    // Handshake control
    always_comb
    begin
        fire           = in_full_reg && (!out_valid_reg || !out_stall);
        in_stall       = in_full_reg && !fire;
        accept_in      = in_valid && !in_stall;
        in_full_next   = accept_in || (in_full_reg && !fire);
        out_valid_next = fire || (out_valid_reg && out_stall);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            item_reg.mode        <= mode;
            item_reg.digit_index <= digit_index;
            item_reg.digit_value <= digit_value;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= result;
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chain <= sss_pkg::CHAIN_W'(sss_pkg::CHAIN_RESET);
            cfg_reg.dwell <= sss_pkg::DWELL_BITS'(sss_pkg::DWELL_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sss_pkg::REG_MODULE_CHAIN: cfg_reg.chain <= cfg_data[sss_pkg::CHAIN_W-1:0];
                sss_pkg::REG_DWELL_TICKS:  cfg_reg.dwell <= cfg_data;
            endcase
        end
    end

    sss_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fire && (item_reg.mode == sss_pkg::MODE_WRITE)),
        .wr_idx  (item_reg.digit_index),
        .wr_data (item_reg.digit_value),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    sss_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .rd_data (rd_data),
        .rd_idx  (rd_idx),
        .result  (result)
    );

    // Drive result ports
    assign out_valid     = out_valid_reg;
    assign shift_clock   = res_reg.pins.clk;
    assign shift_data    = res_reg.pins.data;
    assign latch_out     = res_reg.pins.latch;
    assign scan_position = sss_pkg::SCAN_POS_W'(res_reg.pos);

    `SSS_ASSERT_IMPL(a_stall_full, in_stall, in_full_reg && out_valid_reg, "input stalled without pending work")
    `SSS_ASSERT_NEXT(a_fire_result, fire, out_valid_reg, "processed item produced no result")
    `SSS_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg && $stable(res_reg), "stalled result changed")

endmodule

@@ sim/scan_shifter_checker.sv @@
// Checker for the seven-segment scan shifter: predicts the pin levels of every transaction and compares.
module scan_shifter_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               mode,
    input  logic [sss_pkg::IDX_W-1:0]          digit_index,
    input  logic [sss_pkg::SEG_BITS-1:0]       digit_value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               shift_clock,
    input  logic                               shift_data,
    input  logic                               latch_out,
    input  logic [sss_pkg::SCAN_POS_W-1:0]     scan_position,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sss_pkg::DWELL_BITS-1:0]     cfg_data,
    output int                                 mismatch_count,
    output int                                 pending_count,
    output int                                 results_checked
);

    // Shadow copy of the scan state and the two registers
    logic [sss_pkg::SEG_BITS-1:0]     seg_store [sss_pkg::MAX_DIGITS];
    logic [sss_pkg::DIGIT_W-1:0]      cur_digit;
    logic [5:0]                       phase;
    logic [sss_pkg::DWELL_BITS-1:0]   hold_count;
    logic [sss_pkg::WORD_BITS-1:0]    shift_word;
    sss_pkg::pins_t                   pins;
    logic [sss_pkg::CHAIN_W-1:0]      chain_cfg;
    logic [sss_pkg::DWELL_BITS-1:0]   dwell_cfg;

    // Expected pin levels, oldest first
    sss_pkg::result_t                 pin_queue [$];

    // Chain setting 0 behaves as one module, 3 as two
    function automatic int digits_scanned();
        if (chain_cfg >= 2'd2)
            return 2 * sss_pkg::DIGITS_PER_MODULE;
        return sss_pkg::DIGITS_PER_MODULE;
    endfunction

    // Emit one half bit of the current word; load the word at the start of a digit
    function automatic void shift_half_bit();
        int         n;
        logic [3:0] bit_sel;
        if (phase == 6'd0)
        begin
            n = digits_scanned();
            if (int'(cur_digit) >= n)
                cur_digit = '0;
            shift_word = {seg_store[cur_digit], 8'(1 << (n - 1 - int'(cur_digit)))};
        end
        bit_sel = 4'(sss_pkg::WORD_BITS - 1 - int'(phase >> 1));
        if (!phase[0])
        begin
            pins      = '0;
            pins.data = shift_word[bit_sel];
        end
        else
        begin
            pins.clk   = 1'b1;
            pins.latch = 1'b0;
        end
        phase = phase + 6'd1;
    endfunction

    // Advance the scan by one tick: shift, latch, hold, then move to the next digit
    function automatic void advance_scan();
        int n;
        if (int'(phase) < sss_pkg::LATCH_PHASE)
            shift_half_bit();
        else if (int'(phase) == sss_pkg::LATCH_PHASE)
        begin
            pins.latch = 1'b1;
            phase      = 6'(sss_pkg::LATCH_PHASE + 1);
            hold_count = '0;
        end
        else if (hold_count < dwell_cfg)
        begin
            pins.latch = 1'b0;
            hold_count = hold_count + 1'b1;
        end
        else
        begin
            n = digits_scanned();
            if (int'(cur_digit) + 1 >= n)
                cur_digit = '0;
            else
                cur_digit = cur_digit + 1'b1;
            phase      = '0;
            hold_count = '0;
            shift_half_bit();
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sss_pkg::result_t want;
        if (!rst_n)
        begin
            foreach (seg_store[i])
                seg_store[i] = '0;
            cur_digit       = '0;
            phase           = '0;
            hold_count      = '0;
            shift_word      = '0;
            pins            = '0;
            chain_cfg       = 2'(sss_pkg::CHAIN_RESET);
            dwell_cfg       = 20'(sss_pkg::DWELL_RESET);
            pin_queue.delete();
            mismatch_count  = 0;
            pending_count   = 0;
            results_checked = 0;
        end
        else
        begin
            // Compare an accepted result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (pin_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got clk %0b data %0b latch %0b pos %0d",
                             $time, shift_clock, shift_data, latch_out, scan_position);
                    mismatch_count++;
                end
                else
                begin
                    want = pin_queue.pop_front();
                    check_field("shift_clock", want.pins.clk, shift_clock);
                    check_field("shift_data", want.pins.data, shift_data);
                    check_field("latch_out", want.pins.latch, latch_out);
                    check_field("scan_position", want.pos, scan_position);
                    results_checked++;
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sss_pkg::REG_MODULE_CHAIN)
                    chain_cfg = cfg_data[sss_pkg::CHAIN_W-1:0];
                else
                    dwell_cfg = cfg_data;
            end

            // Predict the result of an accepted item
            if (in_valid && !in_stall)
            begin
                if (mode == sss_pkg::MODE_TICK)
                    advance_scan();
                else
                    seg_store[digit_index] = digit_value;
                want.pins = pins;
                want.pos  = cur_digit;
                pin_queue.push_back(want);
            end
            pending_count = pin_queue.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// Top of the scan shifter bench: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module testbench;

    localparam int NUM_PHASES     = 7;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic                               mode;
    logic [sss_pkg::IDX_W-1:0]          digit_index;
    logic [sss_pkg::SEG_BITS-1:0]       digit_value;
    logic                               out_valid;
    logic                               out_stall;
    logic                               shift_clock;
    logic                               shift_data;
    logic                               latch_out;
    logic [sss_pkg::SCAN_POS_W-1:0]     scan_position;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [sss_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [sss_pkg::DWELL_BITS-1:0]     cfg_data;

    int mismatch_count;
    int pending_count;
    int results_checked;

    // Shared between the sender and the receiver
    bit in_idle_on;
    bit out_idle_on;
    int holds_asked;
    int ticks_sent;
    int writes_sent;
    int reg_writes;
    int idle_cycles;

    // Register settings per phase: chain extremes, dwell extremes, mid-hold and shrink cases
    logic [1:0]  chain_set   [NUM_PHASES] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2};
    logic [19:0] dwell_set   [NUM_PHASES] = '{20'd0, 20'd1, 20'd3, 20'hFFFFF, 20'd2, 20'd5, 20'd0};
    int          phase_items [NUM_PHASES] = '{260, 260, 260, 80, 300, 260, 260};

    seven_segment_scan_shifter_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .digit_index   (digit_index),
        .digit_value   (digit_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shift_clock   (shift_clock),
        .shift_data    (shift_data),
        .latch_out     (latch_out),
        .scan_position (scan_position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    scan_shifter_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .digit_index     (digit_index),
        .digit_value     (digit_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .shift_clock     (shift_clock),
        .shift_data      (shift_data),
        .latch_out       (latch_out),
        .scan_position   (scan_position),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, optionally after an idle burst, and hold it until accepted
    task automatic push_item(input logic m, input logic [2:0] idx, input logic [7:0] val);
        int gap;
        gap = 0;
        if (in_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        digit_index <= idx;
        digit_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == sss_pkg::MODE_TICK)
            ticks_sent++;
        else
            writes_sent++;
    endtask

    // Mostly ticks, with slot writes mixed in mid-scan
    task automatic push_random();
        if ($urandom_range(0, 6) == 0)
            push_item(sss_pkg::MODE_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        else
            push_item(sss_pkg::MODE_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input sss_pkg::cfg_reg_e idx, input logic [19:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Drop valid and let every outstanding transaction come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Receiver: random stall bursts, plus long hold-offs on request
    initial
    begin : receiver
        int burst;
        int holds_done;
        burst      = 0;
        holds_done = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                burst = LONG_HOLD;
            end
            else if (burst == 0 && out_idle_on && $urandom_range(0, 4) == 0)
                burst = $urandom_range(1, 11);
            out_stall <= (burst > 0);
            if (burst > 0)
                burst--;
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] edge_vals [8];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = sss_pkg::MODE_WRITE;
        digit_index = '0;
        digit_value = '0;
        cfg_valid   = 1'b0;
        cfg_index   = sss_pkg::REG_MODULE_CHAIN;
        cfg_data    = '0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        holds_asked = 0;
        ticks_sent  = 0;
        writes_sent = 0;
        reg_writes  = 0;
        edge_vals   = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7F, 8'hFE};

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: ticks on an empty store, every slot with edge values, then shift digit 0
        push_item(sss_pkg::MODE_TICK, 3'd7, 8'hFF);
        push_item(sss_pkg::MODE_TICK, 3'd0, 8'h00);
        for (int i = 0; i < 8; i++)
            push_item(sss_pkg::MODE_WRITE, 3'(i), edge_vals[i]);
        repeat (15)
            push_item(sss_pkg::MODE_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            repeat (4)
                @(posedge clk);
            write_reg(sss_pkg::REG_MODULE_CHAIN, 20'(chain_set[p]));
            write_reg(sss_pkg::REG_DWELL_TICKS, dwell_set[p]);
            in_idle_on  = (p != 2) && (p != NUM_PHASES - 1);
            out_idle_on = in_idle_on;
            if (p == 1)
                holds_asked++;
            repeat (phase_items[p])
                push_random();
        end

        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d ticks and %0d slot writes under %0d register writes",
                 ticks_sent, writes_sent, reg_writes);
        $display("chain settings 0 to 3, hold lengths 0 to max, %0d results compared",
                 results_checked);
        if (mismatch_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
